// File: design/b64c_pkg.sv
// Shared types, codes and character tables for the base64 stream codec.
// Used by every module of the codec; depends on nothing.
`timescale 1ns / 1ps

package b64c_pkg;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic CFG_DIRECTION = 1'b0;
    localparam logic CFG_LIMIT     = 1'b1;

    localparam logic DIR_ENCODE = 1'b0;

    localparam logic [7:0]  PAD_CHAR    = 8'h3D;
    localparam logic [6:0]  VAL_PAD     = 7'd64;
    localparam logic [6:0]  VAL_BAD     = 7'd127;
    localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      n_data;
        logic            has_status;
        logic [1:0]      status_kind;
    } bundle_t;

    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'd71 + {2'b00, v};
        end else if (v < 6'd62) begin
            c = {2'b00, v} - 8'd4;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Sextet value of a character, VAL_PAD for the pad character and
    // VAL_BAD for anything outside the alphabet.
    function automatic logic [6:0] char_value(input logic [7:0] c);
        logic [6:0] v;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 7'(c - 8'd71);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c + 8'd4);
        end else if (c == 8'h2B) begin
            v = 7'd62;
        end else if (c == 8'h2F) begin
            v = 7'd63;
        end else if (c == PAD_CHAR) begin
            v = VAL_PAD;
        end else begin
            v = VAL_BAD;
        end
        return v;
    endfunction

endpackage

// File: design/b64c_core.sv
// Codec core: configuration registers, stream state and the single-pass
// encode and decode logic that turns one input item into a result bundle.
// Depends on b64c_pkg.
`timescale 1ns / 1ps

module b64c_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               item_valid,
    input  b64c_pkg::in_item_t item,
    input  logic               bundle_free,
    output logic               item_fire,
    output logic               bundle_load,
    output b64c_pkg::bundle_t  bundle
);

    logic        dir_reg;
    logic [31:0] limit_reg;
    logic [23:0] bits_reg, bits_next;
    logic [1:0]  gcount_reg, gcount_next;
    logic [1:0]  pads_reg, pads_next;
    logic [31:0] emitted_reg, emitted_next;
    logic        fault_reg, fault_next;

    logic [23:0] enc_bits, enc_grp;
    logic [1:0]  enc_cnt;
    logic        ignore;
    logic [6:0]  val;
    logic [5:0]  sext;
    logic [23:0] dec_bits;
    logic [1:0]  dec_cnt, clip;
    logic [31:0] room;
    logic        no_room;
    logic [2:0]  total;

    always_comb begin
        bits_next    = bits_reg;
        gcount_next  = gcount_reg;
        pads_next    = pads_reg;
        emitted_next = emitted_reg;
        fault_next   = fault_reg;
        bundle       = '0;
        enc_bits     = {bits_reg[15:0], item.in_byte};
        enc_cnt      = gcount_reg + 2'd1;
        enc_grp      = '0;
        ignore       = fault_reg || (gcount_reg == 2'd0 && emitted_reg >= limit_reg);
        val          = b64c_pkg::char_value(item.in_byte);
        if (item.in_byte[7]) begin
            val = b64c_pkg::VAL_BAD;
        end
        sext     = (val == b64c_pkg::VAL_PAD) ? 6'd0 : val[5:0];
        dec_bits = {bits_reg[17:0], sext};
        dec_cnt  = 2'd3;
        no_room  = limit_reg <= emitted_reg;
        room     = limit_reg - emitted_reg;
        clip     = 2'd0;

        if (dir_reg == b64c_pkg::DIR_ENCODE) begin
            bits_next   = enc_bits;
            gcount_next = enc_cnt;
            if (enc_cnt == 2'd3 || item.in_last) begin
                if (enc_cnt == 2'd1) begin
                    enc_grp = {enc_bits[7:0], 16'h0000};
                end else if (enc_cnt == 2'd2) begin
                    enc_grp = {enc_bits[15:0], 8'h00};
                end else begin
                    enc_grp = enc_bits;
                end
                bundle.data[0] = b64c_pkg::alpha_char(enc_grp[23:18]);
                bundle.data[1] = b64c_pkg::alpha_char(enc_grp[17:12]);
                bundle.data[2] = (enc_cnt < 2'd2) ? b64c_pkg::PAD_CHAR
                                                  : b64c_pkg::alpha_char(enc_grp[11:6]);
                bundle.data[3] = (enc_cnt < 2'd3) ? b64c_pkg::PAD_CHAR
                                                  : b64c_pkg::alpha_char(enc_grp[5:0]);
                bundle.n_data  = 3'd4;
                bits_next      = '0;
                gcount_next    = 2'd0;
            end
            bundle.status_kind = b64c_pkg::KIND_OK;
        end else begin
            if (!ignore) begin
                if (val == b64c_pkg::VAL_BAD) begin
                    fault_next = 1'b1;
                end else begin
                    if (val == b64c_pkg::VAL_PAD && gcount_reg == 2'd2) begin
                        pads_next[0] = 1'b1;
                    end
                    if (val == b64c_pkg::VAL_PAD && gcount_reg == 2'd3) begin
                        pads_next[1] = 1'b1;
                    end
                    bits_next = dec_bits;
                    if (gcount_reg == 2'd3) begin
                        if (pads_next[0]) begin
                            dec_cnt = 2'd1;
                        end else if (pads_next[1]) begin
                            dec_cnt = 2'd2;
                        end
                        if (no_room) begin
                            clip = 2'd0;
                        end else if (room < {30'd0, dec_cnt}) begin
                            clip = room[1:0];
                        end else begin
                            clip = dec_cnt;
                        end
                        bundle.data[0] = dec_bits[23:16];
                        bundle.data[1] = dec_bits[15:8];
                        bundle.data[2] = dec_bits[7:0];
                        bundle.n_data  = {1'b0, clip};
                        emitted_next   = emitted_reg + {30'd0, clip};
                        bits_next      = '0;
                        gcount_next    = 2'd0;
                        pads_next      = 2'd0;
                    end else begin
                        gcount_next = gcount_reg + 2'd1;
                    end
                end
            end
            bundle.status_kind = (fault_next || gcount_next != 2'd0) ? b64c_pkg::KIND_ERR
                                                                     : b64c_pkg::KIND_OK;
        end

        if (item.in_last) begin
            bundle.has_status = 1'b1;
            bits_next         = '0;
            gcount_next       = 2'd0;
            pads_next         = 2'd0;
            emitted_next      = '0;
            fault_next        = 1'b0;
        end

        total       = bundle.n_data + {2'b00, bundle.has_status};
        item_fire   = item_valid && (total == 3'd0 || bundle_free);
        bundle_load = item_fire && total != 3'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg     <= b64c_pkg::DIR_ENCODE;
            limit_reg   <= b64c_pkg::LIMIT_RESET;
            bits_reg    <= '0;
            gcount_reg  <= '0;
            pads_reg    <= '0;
            emitted_reg <= '0;
            fault_reg   <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_index == b64c_pkg::CFG_DIRECTION) begin
                dir_reg     <= cfg_wdata[0];
                bits_reg    <= '0;
                gcount_reg  <= '0;
                pads_reg    <= '0;
                emitted_reg <= '0;
                fault_reg   <= 1'b0;
            end else begin
                limit_reg <= cfg_wdata;
            end
        end else if (item_fire) begin
            bits_reg    <= bits_next;
            gcount_reg  <= gcount_next;
            pads_reg    <= pads_next;
            emitted_reg <= emitted_next;
            fault_reg   <= fault_next;
        end
    end

endmodule

// File: design/b64c_serializer.sv
// Result register: holds one bundle of up to five results and hands them
// out one per cycle on the result channel while m_ready is high. Depends on b64c_pkg.
`timescale 1ns / 1ps

module b64c_serializer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              bundle_load,
    input  b64c_pkg::bundle_t bundle,
    output logic              bundle_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic [1:0]        m_out_kind,
    output logic              m_out_last
);

    b64c_pkg::bundle_t bundle_reg;
    logic              busy_reg;
    logic [2:0]        pos_reg;
    logic [2:0]        total;
    logic              is_data;
    logic              take;

    always_comb begin
        total       = bundle_reg.n_data + {2'b00, bundle_reg.has_status};
        is_data     = pos_reg < bundle_reg.n_data;
        m_valid     = busy_reg;
        m_out_byte  = is_data ? bundle_reg.data[pos_reg[1:0]] : 8'h00;
        m_out_kind  = is_data ? b64c_pkg::KIND_DATA : bundle_reg.status_kind;
        m_out_last  = (pos_reg + 3'd1) == total;
        take        = busy_reg && m_ready;
        bundle_free = !busy_reg || (take && m_out_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else if (bundle_load) begin
            busy_reg <= 1'b1;
            pos_reg  <= '0;
        end else if (take) begin
            busy_reg <= !m_out_last;
            pos_reg  <= pos_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (bundle_load) begin
            bundle_reg <= bundle;
        end
    end

endmodule

// File: design/base64_stream_codec.sv
// Streaming base64 codec, standard alphabet with '=' padding, encode or decode
// selected by the direction register. Top level: input register, core, output.
// Depends on b64c_pkg, b64c_core and b64c_serializer.
`timescale 1ns / 1ps

// An input request that causes no result does not wait for the output, so such
// requests are taken back to back. Every result occupies the output port until
// it is accepted: three encoded bytes give four characters, a full decode group
// gives up to three bytes, and the last request of a stream adds one status
// result. The next request is processed while the previous results are still
// being delivered, so throughput is set by the number of results. The first
// result of a request passes through the input register and the result
// register before it is offered.
module base64_stream_codec (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_out_kind,
    output logic        m_out_last
);

    b64c_pkg::in_item_t item_reg;
    logic               item_valid_reg;
    logic               item_fire;
    logic               bundle_load;
    logic               bundle_free;
    b64c_pkg::bundle_t  bundle;

    assign s_ready = !item_valid_reg || item_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.in_byte <= s_in_byte;
            item_reg.in_last <= s_in_last;
        end
    end

    b64c_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .item_valid  (item_valid_reg),
        .item        (item_reg),
        .bundle_free (bundle_free),
        .item_fire   (item_fire),
        .bundle_load (bundle_load),
        .bundle      (bundle)
    );

    b64c_serializer u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .bundle_load (bundle_load),
        .bundle      (bundle),
        .bundle_free (bundle_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_kind  (m_out_kind),
        .m_out_last  (m_out_last)
    );

endmodule
